[hdl/lhd_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the Lavet stepper hand driver.
// No dependencies; used by the interfaces, the core and the checker.
package lhd_pkg;

   localparam int TICKS_PER_REV_DEF = 360;

   localparam int TIME_W   = 32;
   localparam int DUR_W    = 16;
   localparam int THR_W    = 9;
   localparam int TARGET_W = 16;
   localparam int HAND_W   = 9;
   localparam int PHASE_W  = 3;
   localparam int COIL_N   = 4;

   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   localparam logic [1:0] CSR_DRIVE_TIME = 2'd0;
   localparam logic [1:0] CSR_WAIT_TIME  = 2'd1;
   localparam logic [1:0] CSR_REV_THRESH = 2'd2;

   localparam logic [DUR_W-1:0] DRIVE_TIME_RST = 16'd10;
   localparam logic [DUR_W-1:0] WAIT_TIME_RST  = 16'd20;
   localparam logic [THR_W-1:0] REV_THRESH_RST = 9'd180;

   localparam int COIL_F0 = 0;
   localparam int COIL_F1 = 1;
   localparam int COIL_R0 = 2;
   localparam int COIL_R1 = 3;
   localparam logic [COIL_N-1:0] COILS_RELEASED = 4'b1111;

   typedef enum logic [PHASE_W-1:0] {
      PH_IDLE   = 3'd0,
      PH_DRV_F  = 3'd1,
      PH_DRV_R  = 3'd2,
      PH_WAIT_F = 3'd3,
      PH_WAIT_R = 3'd4
   } phase_type;

endpackage

[hdl/lhd_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response words.
// Depends on lhd_pkg for field widths.
interface lhd_req_if;
   import lhd_pkg::*;

   logic                valid;
   logic                ready;
   logic                func;
   logic [TIME_W-1:0]   now_ms;
   logic signed [TARGET_W-1:0] target_angle;

   modport source (output valid, func, now_ms, target_angle, input ready);
   modport sink   (input valid, func, now_ms, target_angle, output ready);
endinterface

interface lhd_rsp_if;
   import lhd_pkg::*;

   logic                valid;
   logic                ready;
   logic                coil_f0;
   logic                coil_f1;
   logic                coil_r0;
   logic                coil_r1;
   logic [HAND_W-1:0]   hand_angle;
   logic [PHASE_W-1:0]  phase;
   logic                pole_now;

   modport source (output valid, coil_f0, coil_f1, coil_r0, coil_r1, hand_angle, phase,
                   pole_now, input ready);
   modport sink   (input valid, coil_f0, coil_f1, coil_r0, coil_r1, hand_angle, phase,
                   pole_now, output ready);
endinterface

[hdl/lavet_stepper_hand_driver.sv]
`timescale 1ns / 1ps
// Top level of the Lavet stepper hand driver: CSRs, request register, step logic,
// response register. Depends on lhd_pkg, lhd_if and lhd_angle_wrap.
// A word accepted goes into the request register, then into the response register when that is free.
// Throughput: one word per clock unless the response side stalls; req_ch.ready follows rsp_ch.ready.
// Reset: synchronous, active high; coils released, idle, angles and pulse time zero,
// CSRs back to drive 10 ms, wait 20 ms, threshold 180.
module lavet_stepper_hand_driver #(
   parameter int TICKS_PER_REV = lhd_pkg::TICKS_PER_REV_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   lhd_req_if.sink                     req_ch,
   lhd_rsp_if.source                   rsp_ch,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [lhd_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [lhd_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [lhd_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);
   import lhd_pkg::*;

   localparam int AW = $clog2(TICKS_PER_REV);
   localparam int DW = (AW + 1 > THR_W) ? AW + 1 : THR_W;

   localparam logic [AW-1:0] LAST_TICK = AW'(TICKS_PER_REV - 1);
   localparam logic [AW:0]   TICKS_X   = (AW+1)'(TICKS_PER_REV);

   // CSRs
   logic [DUR_W-1:0] drive_ff, drive_in;
   logic [DUR_W-1:0] wait_ff, wait_in;
   logic [THR_W-1:0] thr_ff, thr_in;
   logic             csr_wr;

   // request register
   logic                       in_valid_ff, in_valid_in;
   logic                       in_func_ff;
   logic [TIME_W-1:0]          in_now_ff;
   logic signed [TARGET_W-1:0] in_tgt_ff;

   // motor state
   phase_type          phase_ff, phase_in;
   logic               pole_ff, pole_in;
   logic [AW-1:0]      meas_ff, meas_in;
   logic [AW-1:0]      cmd_ff, cmd_in;
   logic [TIME_W-1:0]  start_ff, start_in;
   logic [COIL_N-1:0]  coil_ff, coil_in;

   // response register
   logic               out_valid_ff, out_valid_in;
   logic [COIL_N-1:0]  out_coil_ff;
   logic [HAND_W-1:0]  out_hand_ff;
   logic [PHASE_W-1:0] out_phase_ff;
   logic               out_pole_ff;

   logic              advance;
   logic [AW-1:0]     tgt_wrapped;
   logic [AW:0]       fwd_dist;
   logic              fwd_ok;
   logic [TIME_W-1:0] elapsed;
   logic [DUR_W:0]    total_time;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      drive_in = drive_ff;
      wait_in  = wait_ff;
      thr_in   = thr_ff;
      if (csr_wr) begin
         case (csr_paddr[3:2])
            CSR_DRIVE_TIME: drive_in = csr_pwdata[DUR_W-1:0];
            CSR_WAIT_TIME:  wait_in  = csr_pwdata[DUR_W-1:0];
            CSR_REV_THRESH: thr_in   = csr_pwdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         CSR_DRIVE_TIME: csr_prdata = CSR_DW'(drive_ff);
         CSR_WAIT_TIME:  csr_prdata = CSR_DW'(wait_ff);
         CSR_REV_THRESH: csr_prdata = CSR_DW'(thr_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // handshake
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign in_valid_in  = req_ch.valid || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);

   lhd_angle_wrap #(
      .TICKS_PER_REV (TICKS_PER_REV)
   ) u_wrap (
      .angle   (in_tgt_ff),
      .wrapped (tgt_wrapped)
   );

   assign fwd_dist   = (cmd_ff > meas_ff) ? {1'b0, cmd_ff} - {1'b0, meas_ff}
                                          : TICKS_X - {1'b0, meas_ff} + {1'b0, cmd_ff};
   assign fwd_ok     = DW'(fwd_dist) <= DW'(thr_ff);
   assign elapsed    = in_now_ff - start_ff;
   assign total_time = {1'b0, drive_ff} + {1'b0, wait_ff};

   always_comb begin
      phase_in = phase_ff;
      pole_in  = pole_ff;
      meas_in  = meas_ff;
      cmd_in   = cmd_ff;
      start_in = start_ff;
      coil_in  = coil_ff;
      if (advance) begin
         if (in_func_ff) begin
            cmd_in = tgt_wrapped;
         end else begin
            case (phase_ff)
               PH_IDLE: begin
                  if (meas_ff != cmd_ff) begin
                     if (fwd_ok) begin
                        coil_in[pole_ff ? COIL_F1 : COIL_F0] = 1'b0;
                        phase_in = PH_DRV_F;
                     end else begin
                        coil_in[pole_ff ? COIL_R1 : COIL_R0] = 1'b0;
                        phase_in = PH_DRV_R;
                     end
                     start_in = in_now_ff;
                  end
               end
               default: begin
                  if ((phase_ff == PH_DRV_F || phase_ff == PH_DRV_R)
                      && elapsed >= TIME_W'(drive_ff)) begin
                     coil_in  = COILS_RELEASED;
                     phase_in = (phase_ff == PH_DRV_F) ? PH_WAIT_F : PH_WAIT_R;
                  end
                  if ((phase_in == PH_WAIT_F || phase_in == PH_WAIT_R)
                      && elapsed >= TIME_W'(total_time)) begin
                     pole_in = !pole_ff;
                     if (phase_in == PH_WAIT_F) begin
                        meas_in = (meas_ff == LAST_TICK) ? '0 : meas_ff + 1'b1;
                     end else begin
                        meas_in = (meas_ff == '0) ? LAST_TICK : meas_ff - 1'b1;
                     end
                     phase_in = PH_IDLE;
                     start_in = '0;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_ff     <= DRIVE_TIME_RST;
         wait_ff      <= WAIT_TIME_RST;
         thr_ff       <= REV_THRESH_RST;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         pole_ff      <= 1'b0;
         meas_ff      <= '0;
         cmd_ff       <= '0;
         start_ff     <= '0;
         coil_ff      <= COILS_RELEASED;
      end else begin
         drive_ff     <= drive_in;
         wait_ff      <= wait_in;
         thr_ff       <= thr_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
         pole_ff      <= pole_in;
         meas_ff      <= meas_in;
         cmd_ff       <= cmd_in;
         start_ff     <= start_in;
         coil_ff      <= coil_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_func_ff <= req_ch.func;
         in_now_ff  <= req_ch.now_ms;
         in_tgt_ff  <= req_ch.target_angle;
      end
      if (advance) begin
         out_coil_ff  <= coil_in;
         out_hand_ff  <= HAND_W'(meas_in);
         out_phase_ff <= phase_in;
         out_pole_ff  <= pole_in;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.coil_f0    = out_coil_ff[COIL_F0];
   assign rsp_ch.coil_f1    = out_coil_ff[COIL_F1];
   assign rsp_ch.coil_r0    = out_coil_ff[COIL_R0];
   assign rsp_ch.coil_r1    = out_coil_ff[COIL_R1];
   assign rsp_ch.hand_angle = out_hand_ff;
   assign rsp_ch.phase      = out_phase_ff;
   assign rsp_ch.pole_now   = out_pole_ff;

endmodule

[hdl/lhd_angle_wrap.sv]
`timescale 1ns / 1ps
// Reduces a signed 16-bit tick count into 0..TICKS_PER_REV-1.
// Byte-wise residue tables plus one correction for the sign weight; uses lhd_pkg.
module lhd_angle_wrap #(
   parameter int TICKS_PER_REV = lhd_pkg::TICKS_PER_REV_DEF
) (
   input  logic signed [lhd_pkg::TARGET_W-1:0] angle,
   output logic [$clog2(TICKS_PER_REV)-1:0]    wrapped
);
   import lhd_pkg::*;

   localparam int AW      = $clog2(TICKS_PER_REV);
   localparam int SIGN_RM = 65536 % TICKS_PER_REV;

   localparam logic [AW:0] TICKS_X = (AW+1)'(TICKS_PER_REV);
   localparam logic [AW:0] SIGN_X  = (AW+1)'(SIGN_RM);

   logic [AW-1:0] hi_rom [256];
   logic [AW-1:0] lo_rom [256];
   logic [AW:0]   sum;
   logic [AW:0]   red;
   logic [AW:0]   res;

   for (genvar g = 0; g < 256; g++) begin : g_rom
      localparam int HI_RM = (g * 256) % TICKS_PER_REV;
      localparam int LO_RM = g % TICKS_PER_REV;
      assign hi_rom[g] = AW'(HI_RM);
      assign lo_rom[g] = AW'(LO_RM);
   end

   always_comb begin
      sum = {1'b0, hi_rom[angle[15:8]]} + {1'b0, lo_rom[angle[7:0]]};
      red = (sum >= TICKS_X) ? sum - TICKS_X : sum;
      // negative input: take off 2^16 mod N
      if (angle[15]) begin
         res = (red < SIGN_X) ? red + TICKS_X - SIGN_X : red - SIGN_X;
      end else begin
         res = red;
      end
   end

   assign wrapped = res[AW-1:0];

endmodule

[hdl/lhd_checker.sv]
`timescale 1ns / 1ps
// Port-level checks on the response channel of the hand driver, with its bind.
// Depends on lhd_pkg and lavet_stepper_hand_driver.
module lhd_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        coil_f0,
   input logic                        coil_f1,
   input logic                        coil_r0,
   input logic                        coil_r1,
   input logic [lhd_pkg::HAND_W-1:0]  hand_angle,
   input logic [lhd_pkg::PHASE_W-1:0] phase,
   input logic                        pole_now
);
   import lhd_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   a_stall_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable({coil_f0, coil_f1, coil_r0, coil_r1, hand_angle, phase, pole_now}))
      else $error("response word changed while stalled");

   // driving phase pulls exactly the line picked by direction and pole
   a_drive_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (phase == PH_DRV_F || phase == PH_DRV_R) |->
         ((phase == PH_DRV_F) ? (coil_r0 && coil_r1 && coil_f0 == pole_now
                                 && coil_f1 == !pole_now)
                              : (coil_f0 && coil_f1 && coil_r0 == pole_now
                                 && coil_r1 == !pole_now)))
      else $error("wrong coil line driven");

   a_rest_released: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (phase == PH_IDLE || phase == PH_WAIT_F || phase == PH_WAIT_R) |->
         (coil_f0 && coil_f1 && coil_r0 && coil_r1))
      else $error("coil driven outside drive phase");

endmodule

bind lavet_stepper_hand_driver lhd_checker u_lhd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .coil_f0    (rsp_ch.coil_f0),
   .coil_f1    (rsp_ch.coil_f1),
   .coil_r0    (rsp_ch.coil_r0),
   .coil_r1    (rsp_ch.coil_r1),
   .hand_angle (rsp_ch.hand_angle),
   .phase      (rsp_ch.phase),
   .pole_now   (rsp_ch.pole_now)
);

[tb/sv/lhd_motor_checker.sv]
`timescale 1ns / 1ps
// Checker for the Lavet stepper hand driver: tracks CSR writes, predicts the motor
// state for every accepted request word and compares each response word in order.
// Depends on lhd_pkg and the lhd_req_if / lhd_rsp_if channel interfaces.
module lhd_motor_checker #(
   parameter int TICKS_PER_REV = lhd_pkg::TICKS_PER_REV_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   lhd_req_if                          req_mon,
   lhd_rsp_if                          rsp_mon,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [lhd_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [lhd_pkg::CSR_DW-1:0]  csr_pwdata,
   input  logic                        csr_pready,
   output int                          fail_count,
   output int                          pending
);
   import lhd_pkg::*;

   typedef struct packed {
      logic [COIL_N-1:0] coils;
      logic [HAND_W-1:0] hand;
      phase_type         phase;
      logic              pole;
   } motor_view_type;

   logic [DUR_W-1:0]  drive_ms;
   logic [DUR_W-1:0]  rest_ms;
   logic [THR_W-1:0]  rev_thr;
   phase_type         step_phase;
   logic              pole;
   logic [HAND_W-1:0] hand;
   logic [HAND_W-1:0] cmd_angle;
   logic [TIME_W-1:0] pulse_start;
   logic [COIL_N-1:0] coils;

   motor_view_type motor_q[$];
   int             n_fail = 0;

   assign fail_count = n_fail;
   assign pending    = motor_q.size();

   function automatic logic [HAND_W-1:0] reduce_angle(logic signed [TARGET_W-1:0] raw);
      int r;
      r = int'(raw) % TICKS_PER_REV;
      if (r < 0)
         r += TICKS_PER_REV;
      return HAND_W'(r);
   endfunction

   task automatic advance_time(input logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] elapsed;
      int                fwd;
      if (step_phase == PH_IDLE) begin
         if (hand != cmd_angle) begin
            if (cmd_angle > hand)
               fwd = int'(cmd_angle) - int'(hand);
            else
               fwd = TICKS_PER_REV - int'(hand) + int'(cmd_angle);
            if (fwd <= int'(rev_thr)) begin
               coils[pole ? COIL_F1 : COIL_F0] = 1'b0;
               step_phase = PH_DRV_F;
            end else begin
               coils[pole ? COIL_R1 : COIL_R0] = 1'b0;
               step_phase = PH_DRV_R;
            end
            pulse_start = now;
         end
      end else begin
         elapsed = now - pulse_start;
         if ((step_phase == PH_DRV_F || step_phase == PH_DRV_R) &&
             elapsed >= TIME_W'(drive_ms)) begin
            coils      = COILS_RELEASED;
            step_phase = (step_phase == PH_DRV_F) ? PH_WAIT_F : PH_WAIT_R;
         end
         // late sample can finish drive and rest in the same word
         if ((step_phase == PH_WAIT_F || step_phase == PH_WAIT_R) &&
             elapsed >= TIME_W'(drive_ms) + TIME_W'(rest_ms)) begin
            pole = ~pole;
            if (step_phase == PH_WAIT_F)
               hand = (int'(hand) + 1 >= TICKS_PER_REV) ? '0 : hand + 1'b1;
            else
               hand = (hand == 0) ? HAND_W'(TICKS_PER_REV - 1) : hand - 1'b1;
            step_phase  = PH_IDLE;
            pulse_start = '0;
         end
      end
   endtask

   task automatic report(input string field, input int exp_val, input int got_val);
      n_fail++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_val, got_val);
   endtask

   task automatic check_word();
      motor_view_type exp_w;
      if (motor_q.size() == 0) begin
         n_fail++;
         $display("%0t: response word with nothing expected, hand_angle %0d phase %0d",
                  $time, rsp_mon.hand_angle, rsp_mon.phase);
      end else begin
         exp_w = motor_q.pop_front();
         if (rsp_mon.coil_f0 !== exp_w.coils[COIL_F0])
            report("coil_f0", exp_w.coils[COIL_F0], rsp_mon.coil_f0);
         if (rsp_mon.coil_f1 !== exp_w.coils[COIL_F1])
            report("coil_f1", exp_w.coils[COIL_F1], rsp_mon.coil_f1);
         if (rsp_mon.coil_r0 !== exp_w.coils[COIL_R0])
            report("coil_r0", exp_w.coils[COIL_R0], rsp_mon.coil_r0);
         if (rsp_mon.coil_r1 !== exp_w.coils[COIL_R1])
            report("coil_r1", exp_w.coils[COIL_R1], rsp_mon.coil_r1);
         if (rsp_mon.hand_angle !== exp_w.hand)
            report("hand_angle", exp_w.hand, rsp_mon.hand_angle);
         if (rsp_mon.phase !== exp_w.phase)
            report("phase", exp_w.phase, rsp_mon.phase);
         if (rsp_mon.pole_now !== exp_w.pole)
            report("pole_now", exp_w.pole, rsp_mon.pole_now);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         drive_ms    = DRIVE_TIME_RST;
         rest_ms     = WAIT_TIME_RST;
         rev_thr     = REV_THRESH_RST;
         step_phase  = PH_IDLE;
         pole        = 1'b0;
         hand        = '0;
         cmd_angle   = '0;
         pulse_start = '0;
         coils       = COILS_RELEASED;
         motor_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready)
            check_word();
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               CSR_DRIVE_TIME: drive_ms = csr_pwdata[DUR_W-1:0];
               CSR_WAIT_TIME:  rest_ms  = csr_pwdata[DUR_W-1:0];
               CSR_REV_THRESH: rev_thr  = csr_pwdata[THR_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.func)
               cmd_angle = reduce_angle(req_mon.target_angle);
            else
               advance_time(req_mon.now_ms);
            motor_q.push_back('{coils, hand, step_phase, pole});
         end
      end
   end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Top of the Lavet stepper hand driver testbench: clock, reset, CSR programming and
// request/response traffic with random gaps. Depends on lhd_pkg, lhd_if and lhd_motor_checker.
module testbench;
   import lhd_pkg::*;

   localparam int STALL_LIMIT = 2000;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CSR_AW-1:0]   csr_paddr;
   logic [CSR_DW-1:0]   csr_pwdata;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   lhd_req_if req();
   lhd_rsp_if rsp();

   int                fail_count;
   int                pending;
   int                words_sent = 0;
   int                stall_cycles = 0;
   logic              steady;
   logic              rsp_hold;
   logic [TIME_W-1:0] ms_clock;

   lavet_stepper_hand_driver u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req),
      .rsp_ch      (rsp),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   lhd_motor_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req),
      .rsp_mon     (rsp),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("lavet_stepper_hand_driver test failed");
            $finish;
         end
      end
   end

   // response side: random back-pressure
   initial begin
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp.ready <= !rsp_hold && (steady || $urandom_range(99) >= 20);
      end
   end

   // long hold-off so the driver fills up and stalls its request side
   initial begin
      rsp_hold <= 1'b0;
      wait (words_sent >= 300);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (300) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   task automatic send_word(input logic f, input logic [TIME_W-1:0] now,
                            input logic [TARGET_W-1:0] tgt);
      while (!steady && $urandom_range(99) < 20) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid        <= 1'b1;
      req.func         <= f;
      req.now_ms       <= now;
      req.target_angle <= tgt;
      do @(posedge clock); while (!req.ready);
      words_sent++;
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [CSR_DW-1:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   // only reprogram once every response has drained
   task automatic configure(input logic [CSR_DW-1:0] drive, input logic [CSR_DW-1:0] rest,
                            input logic [CSR_DW-1:0] thr);
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      write_reg(CSR_DRIVE_TIME, drive);
      write_reg(CSR_WAIT_TIME, rest);
      write_reg(CSR_REV_THRESH, thr);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // mostly advancing time samples, some target changes, some random time noise
   task automatic run_phase(input int n_words, input int step_max);
      int roll;
      for (int i = 0; i < n_words; i++) begin
         roll = $urandom_range(99);
         if (roll < 8) begin
            send_word(1'b1, $urandom, TARGET_W'($urandom));
         end else if (roll < 12) begin
            send_word(1'b0, $urandom, TARGET_W'($urandom));
         end else begin
            ms_clock += $urandom_range(step_max);
            send_word(1'b0, ms_clock, TARGET_W'($urandom));
         end
      end
   endtask

   initial begin
      reset            <= 1'b1;
      steady           <= 1'b0;
      req.valid        <= 1'b0;
      req.func         <= 1'b0;
      req.now_ms       <= '0;
      req.target_angle <= '0;
      csr_psel         <= 1'b0;
      csr_penable      <= 1'b0;
      csr_pwrite       <= 1'b0;
      csr_paddr        <= '0;
      csr_pwdata       <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: default timing, wrap of time and of target angle
      send_word(1'b0, 32'h0000_0000, 16'h0000);
      send_word(1'b1, 32'h1234_5678, 16'h7FFF);
      send_word(1'b0, 32'hFFFF_FFF8, 16'hFFFF);
      send_word(1'b0, 32'hFFFF_FFFC, 16'h0000);
      send_word(1'b0, 32'h0000_0002, 16'h0000);
      send_word(1'b0, 32'h0000_0016, 16'h0000);
      send_word(1'b1, 32'hFFFF_FFFF, 16'h8000);
      send_word(1'b0, 32'd5, 16'h0000);
      send_word(1'b0, 32'd5000, 16'h5555);
      send_word(1'b0, 32'd5001, 16'hAAAA);
      send_word(1'b1, 32'h0000_0000, 16'hFFFF);
      send_word(1'b0, 32'd5011, 16'h0000);
      send_word(1'b0, 32'd5030, 16'h0000);
      send_word(1'b0, 32'd5031, 16'h0000);
      send_word(1'b0, 32'd6000, 16'h0000);
      send_word(1'b1, 32'h0000_0000, 16'd360);
      send_word(1'b0, 32'hFFFF_FFFF, 16'h0000);
      send_word(1'b0, 32'h0000_0000, 16'h0000);
      send_word(1'b1, 32'h0000_0000, 16'd180);
      send_word(1'b0, 32'h7FFF_FFFF, 16'h0000);
      send_word(1'b0, 32'h8000_0000, 16'h7FFF);

      ms_clock = $urandom;
      configure(32'hABCD_0000, 32'h0000_0000, 32'h0000_0000);
      run_phase(100, 3);
      configure(32'h0000_0001, 32'hFFFF_0000, 32'hFFFF_FFFF);
      run_phase(100, 3);
      configure(32'd65535, 32'd65535, 32'd359);
      run_phase(80, 50000);
      steady <= 1'b1;
      configure(32'd3, 32'd7, 32'd360);
      run_phase(100, 8);
      steady <= 1'b0;
      configure($urandom_range(50, 1), $urandom_range(50, 0), $urandom_range(359, 0));
      run_phase(120, 40);
      configure(CSR_DW'(DRIVE_TIME_RST), CSR_DW'(WAIT_TIME_RST), CSR_DW'(REV_THRESH_RST));
      run_phase(100, 15);

      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("lavet_stepper_hand_driver test passed");
      else
         $display("lavet_stepper_hand_driver test failed");
      $finish;
   end

endmodule
